// ----- src/ble_pkg.sv -----
// Shared types, constants and width helpers for the barbell level-set evaluator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ble_pkg;

   localparam int LANE_W = 16;
   localparam int CFG_W = 48;
   localparam int AXIS_W = 32;
   localparam int LEVEL_W = 18;
   localparam int REGION_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int FRACTION_BITS_DEFAULT = 14;
   localparam int QUEUE_DEPTH = 4;

   localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 18'sd131071;
   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -18'sd131072;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_ONE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_TWO = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADII = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHAFT_AXIS = 3'd6;

   localparam logic [CFG_W-1:0] RST_ROW_0 = 48'd16384;
   localparam logic [CFG_W-1:0] RST_ROW_1 = 48'd1073741824;
   localparam logic [CFG_W-1:0] RST_ROW_2 = 48'd70368744177664;
   localparam logic [CFG_W-1:0] RST_CENTRE_ONE = 48'd35184908964659;
   localparam logic [CFG_W-1:0] RST_CENTRE_TWO = 48'd35184908971213;
   localparam logic [CFG_W-1:0] RST_RADII = 48'd2113231259238;
   localparam logic [AXIS_W-1:0] RST_SHAFT_AXIS = 32'd536879104;

   typedef enum logic [REGION_W-1:0] {
      REGION_ONE   = 2'd0,
      REGION_TWO   = 2'd1,
      REGION_NECK  = 2'd2,
      REGION_SHAFT = 2'd3
   } region_type;

   // what the back end must do with the distances of one point
   typedef enum logic [1:0] {
      KIND_ONE      = 2'd0,
      KIND_TWO      = 2'd1,
      KIND_NECK_ONE = 2'd2,
      KIND_NECK_TWO = 2'd3
   } kind_type;

   typedef struct packed {
      logic [CFG_W-1:0]  row_0;
      logic [CFG_W-1:0]  row_1;
      logic [CFG_W-1:0]  row_2;
      logic [CFG_W-1:0]  centre_one;
      logic [CFG_W-1:0]  centre_two;
      logic [CFG_W-1:0]  radii;
      logic [AXIS_W-1:0] shaft_axis;
   } cfg_type;

   // width of a rotated coordinate for a given fraction width
   function automatic int q_width(input int f);
      return (36 - f > 18) ? 36 - f : 18;
   endfunction

   // rotation accumulator width
   function automatic int acc_width(input int f);
      return (f + 19 > 38) ? f + 19 : 38;
   endfunction

   function automatic logic signed [LANE_W-1:0] lane_s(input logic [CFG_W-1:0] w,
                                                       input int k);
      return $signed(w[LANE_W*k +: LANE_W]);
   endfunction

   function automatic logic [LANE_W-1:0] lane_u(input logic [CFG_W-1:0] w, input int k);
      return w[LANE_W*k +: LANE_W];
   endfunction

endpackage
`default_nettype wire

// ----- src/ble_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, rounded to nearest.
// Several lanes share the stage valids and a side payload. Depends on ble_pkg.
`default_nettype none
module ble_sqrt
   import ble_pkg::*;
#(
   parameter int SW = 46,
   parameter int LANES = 1,
   parameter int SIDE_W = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             adv,
   input  wire logic                             in_valid,
   input  wire logic [LANES-1:0][SW-1:0]         in_rad,
   input  wire logic [SIDE_W-1:0]                in_side,
   output logic                                  out_valid,
   output logic [LANES-1:0][SW/2:0]              out_root,
   output logic [SIDE_W-1:0]                     out_side
);
   localparam int N = SW / 2;
   localparam int RMW = N + 3;

   logic [N-1:0][LANES-1:0][RMW-1:0] rem_ff, rem_in;
   logic [N-1:0][LANES-1:0][N-1:0]   root_ff, root_in;
   logic [N-1:0][LANES-1:0][SW-1:0]  rad_ff, rad_in;
   logic [N-1:0][SIDE_W-1:0]         side_ff, side_in;
   logic [N-1:0]                     vld_ff, vld_in;

   // stage inputs: index 0 is the port, index k+1 is stage k
   logic [N:0][LANES-1:0][RMW-1:0] rem_w;
   logic [N:0][LANES-1:0][N-1:0]   root_w;
   logic [N:0][LANES-1:0][SW-1:0]  rad_w;
   logic [N:0][SIDE_W-1:0]         side_w;
   logic [N:0]                     vld_w;

   logic                       out_valid_ff;
   logic [LANES-1:0][N:0]      out_root_ff, out_root_in;
   logic [SIDE_W-1:0]          out_side_ff;

   assign rem_w[0] = '0;
   assign root_w[0] = '0;
   assign rad_w[0] = in_rad;
   assign side_w[0] = in_side;
   assign vld_w[0] = in_valid;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_link
         assign rem_w[g+1] = rem_ff[g];
         assign root_w[g+1] = root_ff[g];
         assign rad_w[g+1] = rad_ff[g];
         assign side_w[g+1] = side_ff[g];
         assign vld_w[g+1] = vld_ff[g];
      end
   endgenerate

   // one digit step per stage: bring down two bits, try to subtract
   always_comb begin
      logic [RMW-1:0] rem_sh;
      logic [RMW-1:0] trial;
      for (int k = 0; k < N; k++) begin
         vld_in[k] = vld_w[k];
         side_in[k] = side_w[k];
         for (int j = 0; j < LANES; j++) begin
            rem_sh = {rem_w[k][j][RMW-3:0], rad_w[k][j][SW-1 -: 2]};
            trial = {1'b0, root_w[k][j], 2'b01};
            rad_in[k][j] = {rad_w[k][j][SW-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in[k][j] = rem_sh - trial;
               root_in[k][j] = {root_w[k][j][N-2:0], 1'b1};
            end else begin
               rem_in[k][j] = rem_sh;
               root_in[k][j] = {root_w[k][j][N-2:0], 1'b0};
            end
         end
      end
   end

   // round up when the remainder exceeds the floor root
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         if (rem_w[N][j] > RMW'(root_w[N][j]))
            out_root_in[j] = (N+1)'(root_w[N][j]) + (N+1)'(1);
         else
            out_root_in[j] = (N+1)'(root_w[N][j]);
      end
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
         out_valid_ff <= vld_w[N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
         rad_ff <= rad_in;
         side_ff <= side_in;
         out_root_ff <= out_root_in;
         out_side_ff <= side_w[N];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_root = out_root_ff;
   assign out_side = out_side_ff;

endmodule
`default_nettype wire

// ----- src/ble_queue.sv -----
// Short queue between the front (rotate, classify) and back (roots, select).
// Depends on ble_pkg.
`default_nettype none
module ble_queue
   import ble_pkg::*;
#(
   parameter int W = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ready,
   input  wire logic [W-1:0] push_data,
   output logic              pop_valid,
   input  wire logic         pop_ready,
   output logic [W-1:0]      pop_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_data = mem_ff[rd_ff];

   // advance pointers with wrap
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      if (pop) rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      if (push && !pop) count_in = count_ff + CW'(1);
      else if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("queue count missed a push");
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("queue count missed a pop");

endmodule
`default_nettype wire

// ----- src/ble_front.sv -----
// Front end: accept a point, rotate it about the centre midpoint, square the
// offsets and classify it along x. Depends on ble_pkg.
`default_nettype none
module ble_front
   import ble_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   parameter int SUMW = 2 * (q_width(FRACTION_BITS) + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cfg_type                 cfg,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [3*LANE_W-1:0]     req_tdata,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [SUMW-1:0]              out_sum_one,
   output logic [SUMW-1:0]              out_sum_two,
   output logic [SUMW-1:0]              out_sum_shaft,
   output kind_type                     out_kind
);
   localparam int F = FRACTION_BITS;
   localparam int QW = q_width(F);
   localparam int DW = QW + 1;
   localparam int AW = acc_width(F);
   localparam int PRW = 2 * LANE_W + 3;
   localparam int CMPW = QW + 2;

   logic adv;
   logic [4:0] vld_ff, vld_in;

   logic signed [LANE_W-1:0] p_ff [3];
   logic signed [PRW-1:0]    prod_ff [3][3], prod_in [3][3];
   logic signed [QW-1:0]     q_ff [3], q_in [3];
   logic [2*DW-1:0]          sq_ff [8], sq_in [8];
   logic [2*LANE_W-1:0]      rs_sq_ff, rs_sq_in;
   logic lt_one_ff, ge_two_ff, first_half_ff, near_one_ff, near_two_ff;
   logic lt_one_in, ge_two_in, first_half_in, near_one_in, near_two_in;
   logic [SUMW-1:0] sum_one_ff, sum_two_ff, sum_shaft_ff;
   logic [SUMW-1:0] sum_one_in, sum_two_in, sum_shaft_in;
   kind_type kind_ff, kind_in;

   logic signed [LANE_W-1:0] c1 [3], c2 [3], row [3][3];
   logic signed [LANE_W:0]   s [3];

   // stall the whole front only when the last stage cannot drain
   assign adv = !vld_ff[4] || out_ready;
   assign req_tready = adv;
   assign vld_in = {vld_ff[3:0], req_tvalid};

   always_comb begin
      for (int m = 0; m < 3; m++) begin
         c1[m] = lane_s(cfg.centre_one, m);
         c2[m] = lane_s(cfg.centre_two, m);
         s[m] = (LANE_W+1)'(c1[m]) + (LANE_W+1)'(c2[m]);
         row[0][m] = lane_s(cfg.row_0, m);
         row[1][m] = lane_s(cfg.row_1, m);
         row[2][m] = lane_s(cfg.row_2, m);
      end
   end

   // matrix products on offsets from the doubled midpoint
   always_comb begin
      logic signed [LANE_W+2:0] d;
      for (int l = 0; l < 3; l++) begin
         for (int m = 0; m < 3; m++) begin
            d = ((LANE_W+3)'(p_ff[m]) <<< 1) - (LANE_W+3)'(s[m]);
            prod_in[l][m] = PRW'(row[l][m]) * PRW'(d);
         end
      end
   end

   // sum, re-center and round to nearest, ties up
   always_comb begin
      logic signed [AW-1:0] acc;
      for (int l = 0; l < 3; l++) begin
         acc = AW'(prod_ff[l][0]) + AW'(prod_ff[l][1]) + AW'(prod_ff[l][2])
             + (AW'(s[l]) <<< F) + (AW'(1) <<< F);
         acc = acc >>> (F + 1);
         q_in[l] = acc[QW-1:0];
      end
   end

   // offsets from centres and shaft axis, squared; position flags along x
   always_comb begin
      logic signed [DW-1:0] dif [8];
      logic signed [CMPW-1:0] qx;
      logic signed [LANE_W+1:0] reach_one, reach_two;
      logic [LANE_W-1:0] rs;
      for (int m = 0; m < 3; m++) begin
         dif[m] = DW'(q_ff[m]) - DW'(c1[m]);
         dif[m+3] = DW'(q_ff[m]) - DW'(c2[m]);
      end
      dif[6] = DW'(q_ff[1]) - DW'(lane_s({16'b0, cfg.shaft_axis}, 0));
      dif[7] = DW'(q_ff[2]) - DW'(lane_s({16'b0, cfg.shaft_axis}, 1));
      for (int k = 0; k < 8; k++) sq_in[k] = (2*DW)'(dif[k] * dif[k]);
      rs = lane_u(cfg.radii, 2);
      rs_sq_in = (2*LANE_W)'(rs) * (2*LANE_W)'(rs);
      qx = CMPW'(q_ff[0]);
      reach_one = (LANE_W+2)'(c1[0]) + $signed({2'b00, lane_u(cfg.radii, 0)});
      reach_two = (LANE_W+2)'(c2[0]) - $signed({2'b00, lane_u(cfg.radii, 1)});
      lt_one_in = qx < CMPW'(c1[0]);
      ge_two_in = qx >= CMPW'(c2[0]);
      first_half_in = (qx <<< 1) <= CMPW'(s[0]);
      near_one_in = qx <= CMPW'(reach_one);
      near_two_in = qx >= CMPW'(reach_two);
   end

   // distance sums and the region decision that needs no root
   always_comb begin
      logic [SUMW-1:0] rad_one, rad_two;
      sum_one_in = SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]);
      sum_two_in = SUMW'(sq_ff[3]) + SUMW'(sq_ff[4]) + SUMW'(sq_ff[5]);
      sum_shaft_in = SUMW'(sq_ff[6]) + SUMW'(sq_ff[7]);
      rad_one = SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]);
      rad_two = SUMW'(sq_ff[4]) + SUMW'(sq_ff[5]);
      priority if (lt_one_ff) kind_in = KIND_ONE;
      else if (ge_two_ff) kind_in = KIND_TWO;
      else if (first_half_ff)
         kind_in = (rad_one > SUMW'(rs_sq_ff) && near_one_ff) ? KIND_ONE : KIND_NECK_ONE;
      else
         kind_in = (rad_two > SUMW'(rs_sq_ff) && near_two_ff) ? KIND_TWO : KIND_NECK_TWO;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= $signed(req_tdata[LANE_W-1:0]);
         p_ff[1] <= $signed(req_tdata[2*LANE_W-1:LANE_W]);
         p_ff[2] <= $signed(req_tdata[3*LANE_W-1:2*LANE_W]);
         prod_ff <= prod_in;
         q_ff <= q_in;
         sq_ff <= sq_in;
         rs_sq_ff <= rs_sq_in;
         lt_one_ff <= lt_one_in;
         ge_two_ff <= ge_two_in;
         first_half_ff <= first_half_in;
         near_one_ff <= near_one_in;
         near_two_ff <= near_two_in;
         sum_one_ff <= sum_one_in;
         sum_two_ff <= sum_two_in;
         sum_shaft_ff <= sum_shaft_in;
         kind_ff <= kind_in;
      end
   end

   assign out_valid = vld_ff[4];
   assign out_sum_one = sum_one_ff;
   assign out_sum_two = sum_two_ff;
   assign out_sum_shaft = sum_shaft_ff;
   assign out_kind = kind_ff;

endmodule
`default_nettype wire

// ----- src/ble_back.sv -----
// Back end: square roots of the distance sums, region select, blended root,
// saturation and the result register. Depends on ble_pkg and ble_sqrt.
`default_nettype none
module ble_back
   import ble_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   parameter int SUMW = 2 * (q_width(FRACTION_BITS) + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [SUMW-1:0]      in_sum_one,
   input  wire logic [SUMW-1:0]      in_sum_two,
   input  wire logic [SUMW-1:0]      in_sum_shaft,
   input  wire kind_type             in_kind,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic signed [LEVEL_W-1:0] level_value,
   output region_type                region
);
   localparam int RW = SUMW / 2 + 1;
   localparam int PW = RW + 1;
   localparam int BSW = 2 * PW;
   localparam int VW = PW + 2;
   localparam int SIDE_W = 1 + REGION_W + PW;

   logic adv;
   logic d_valid;
   logic [2:0][RW-1:0] d_root;
   logic [1:0] d_side;

   logic m_vld_ff, s_vld_ff, out_vld_ff;
   logic [BSW-1:0] sq_a_ff, sq_a_in, sq_s_ff, sq_s_in, sum_ff;
   logic signed [PW-1:0] val_ff, val_in, val_s_ff;
   region_type reg_ff, reg_in, reg_s_ff;
   logic blend_ff, blend_in, blend_s_ff;

   logic b_valid;
   logic [0:0][PW:0] b_root;
   logic [SIDE_W-1:0] b_side;

   logic signed [LEVEL_W-1:0] level_ff, level_in;
   region_type region_ff;

   assign adv = !out_vld_ff || rsp_tready;
   assign in_ready = adv;

   ble_sqrt #(.SW(SUMW), .LANES(3), .SIDE_W(2)) u_dist_root (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(in_valid),
      .in_rad({in_sum_shaft, in_sum_two, in_sum_one}), .in_side(in_kind),
      .out_valid(d_valid), .out_root(d_root), .out_side(d_side)
   );

   // signed distances and the region choice; square for the blend
   always_comb begin
      logic signed [PW-1:0] da, db, ds, phi;
      da = $signed({1'b0, d_root[0]}) - $signed(PW'(lane_u(cfg.radii, 0)));
      db = $signed({1'b0, d_root[1]}) - $signed(PW'(lane_u(cfg.radii, 1)));
      ds = $signed({1'b0, d_root[2]}) - $signed(PW'(lane_u(cfg.radii, 2)));
      phi = da;
      blend_in = 1'b0;
      unique case (kind_type'(d_side))
         KIND_ONE: begin
            val_in = da; reg_in = REGION_ONE;
         end
         KIND_TWO: begin
            val_in = db; reg_in = REGION_TWO;
         end
         KIND_NECK_ONE: begin
            val_in = ds;
            reg_in = (da <= 0) ? REGION_NECK : REGION_SHAFT;
            blend_in = (da <= 0);
         end
         default: begin
            phi = db;
            val_in = ds;
            reg_in = (db < 0) ? REGION_NECK : REGION_SHAFT;
            blend_in = (db < 0);
         end
      endcase
      sq_a_in = BSW'(phi * phi);
      sq_s_in = BSW'(ds * ds);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= d_valid;
         s_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_a_ff <= sq_a_in;
         sq_s_ff <= sq_s_in;
         val_ff <= val_in;
         reg_ff <= reg_in;
         blend_ff <= blend_in;
         sum_ff <= sq_a_ff + sq_s_ff;
         val_s_ff <= val_ff;
         reg_s_ff <= reg_ff;
         blend_s_ff <= blend_ff;
      end
   end

   ble_sqrt #(.SW(BSW), .LANES(1), .SIDE_W(SIDE_W)) u_blend_root (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(s_vld_ff),
      .in_rad(sum_ff), .in_side({blend_s_ff, reg_s_ff, val_s_ff}),
      .out_valid(b_valid), .out_root(b_root), .out_side(b_side)
   );

   // pick blended or direct value, saturate to the output range
   always_comb begin
      logic signed [VW-1:0] v;
      if (b_side[SIDE_W-1]) v = -$signed(VW'(b_root[0]));
      else v = VW'($signed(b_side[PW-1:0]));
      priority if (v > VW'(LEVEL_MAX)) level_in = LEVEL_MAX;
      else if (v < VW'(LEVEL_MIN)) level_in = LEVEL_MIN;
      else level_in = v[LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= b_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         level_ff <= level_in;
         region_ff <= region_type'(b_side[PW +: REGION_W]);
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign level_value = level_ff;
   assign region = region_ff;

   a_neck_negative: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && region == REGION_NECK) |-> (level_value <= 0))
      else $error("blended value not negative");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_tready) |=> (m_vld_ff == $past(m_vld_ff)))
      else $error("back pipe moved while output stalled");
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      !out_vld_ff |-> in_ready)
      else $error("back not ready with empty output");

endmodule
`default_nettype wire

// ----- src/barbell_level_set_eval.sv -----
// Barbell level-set evaluator: one rotated grid point in, value and region out.
// From req accept to rsp_tvalid a point passes 5 front stages, the queue and two
// digit-per-stage root pipelines.
// Throughput one item per cycle while rsp_tready does not stall the output; the root pipelines set the latency.
// Synchronous active-high reset clears valids and queue and reloads the
// configuration defaults.
// Depends on ble_pkg, ble_front, ble_queue, ble_back, ble_sqrt.
`default_nettype none
module barbell_level_set_eval
   import ble_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [3*LANE_W-1:0]    req_tdata,   // point_x, point_y, point_z
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [23:0]                 rsp_tdata,   // level_value, region, zero fill
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_wdata
);
   localparam int SUMW = 2 * (q_width(FRACTION_BITS) + 1);
   localparam int QDW = 3 * SUMW + 2;

   cfg_type cfg_ff;

   logic f_valid, f_ready, b_valid, b_ready;
   logic [SUMW-1:0] f_one, f_two, f_shaft;
   kind_type f_kind;
   logic [QDW-1:0] b_data;
   logic signed [LEVEL_W-1:0] level_value;
   region_type region;

   // configuration writes; unused indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_0 <= RST_ROW_0;
         cfg_ff.row_1 <= RST_ROW_1;
         cfg_ff.row_2 <= RST_ROW_2;
         cfg_ff.centre_one <= RST_CENTRE_ONE;
         cfg_ff.centre_two <= RST_CENTRE_TWO;
         cfg_ff.radii <= RST_RADII;
         cfg_ff.shaft_axis <= RST_SHAFT_AXIS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_0: cfg_ff.row_0 <= csr_wdata;
            CSR_ROW_1: cfg_ff.row_1 <= csr_wdata;
            CSR_ROW_2: cfg_ff.row_2 <= csr_wdata;
            CSR_CENTRE_ONE: cfg_ff.centre_one <= csr_wdata;
            CSR_CENTRE_TWO: cfg_ff.centre_two <= csr_wdata;
            CSR_RADII: cfg_ff.radii <= csr_wdata;
            CSR_SHAFT_AXIS: cfg_ff.shaft_axis <= csr_wdata[AXIS_W-1:0];
            default: ;
         endcase
      end
   end

   ble_front #(.FRACTION_BITS(FRACTION_BITS), .SUMW(SUMW)) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .out_valid(f_valid), .out_ready(f_ready),
      .out_sum_one(f_one), .out_sum_two(f_two), .out_sum_shaft(f_shaft),
      .out_kind(f_kind)
   );

   ble_queue #(.W(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push_valid(f_valid), .push_ready(f_ready),
      .push_data({f_kind, f_shaft, f_two, f_one}),
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
   );

   ble_back #(.FRACTION_BITS(FRACTION_BITS), .SUMW(SUMW)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(b_valid), .in_ready(b_ready),
      .in_sum_one(b_data[SUMW-1:0]),
      .in_sum_two(b_data[2*SUMW-1:SUMW]),
      .in_sum_shaft(b_data[3*SUMW-1:2*SUMW]),
      .in_kind(kind_type'(b_data[QDW-1:3*SUMW])),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .level_value(level_value), .region(region)
   );

   assign rsp_tdata = {4'b0000, region, level_value};

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for barbell_level_set_eval: streams grid points through the block
// and checks every level value and region against an in-bench predictor.
// Depends on ble_pkg and the barbell_level_set_eval RTL only.
`timescale 1ns / 1ps
module tb;
   import ble_pkg::*;

   typedef struct {
      logic signed [LEVEL_W-1:0] level;
      region_type                region;
   } level_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [3*LANE_W-1:0]    req_tdata;    // point_x, point_y, point_z
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [23:0]            rsp_tdata;    // level_value, region, zero fill
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   barbell_level_set_eval u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the configuration
   logic [CFG_W-1:0]  rot_row [3];
   logic [CFG_W-1:0]  ctr_one, ctr_two, radius_set;
   logic [AXIS_W-1:0] axis_pos;

   logic [3*LANE_W-1:0] point_q[$];
   level_result_type    level_q[$];
   int                  mismatches = 0;
   int                  stall_cycles = 0;
   bit                  quiet = 1'b0;
   bit                  hold_go = 1'b0;
   logic                hold_done;
   int                  hold_cnt;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint lane_sgn(input logic [CFG_W-1:0] w, input int k);
      longint r;
      r = $signed(w[16*k +: 16]);
      return r;
   endfunction

   // nearest integer root of a sum of squares
   function automatic longint root_round(input longint unsigned s);
      longint unsigned r, t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= s) r = t;
      end
      if (s - r * r > r) r++;
      return longint'(r);
   endfunction

   // level value and region of one grid point
   function automatic level_result_type barbell_level(input logic [3*LANE_W-1:0] pt);
      longint p[3], a[3], b[3], s[3], q[3];
      longint acc, ra, rb, rs, ay, az, da, db, ds, val, rad;
      level_result_type res;
      for (int m = 0; m < 3; m++) begin
         p[m] = lane_sgn(pt, m);
         a[m] = lane_sgn(ctr_one, m);
         b[m] = lane_sgn(ctr_two, m);
         s[m] = a[m] + b[m];
      end
      for (int l = 0; l < 3; l++) begin
         acc = s[l] * 16384;
         for (int m = 0; m < 3; m++) acc += lane_sgn(rot_row[l], m) * (2 * p[m] - s[m]);
         q[l] = (acc + 16384) >>> 15;
      end
      ra = radius_set[15:0];
      rb = radius_set[31:16];
      rs = radius_set[47:32];
      ay = lane_sgn({16'd0, axis_pos}, 0);
      az = lane_sgn({16'd0, axis_pos}, 1);
      da = root_round((q[0]-a[0])**2 + (q[1]-a[1])**2 + (q[2]-a[2])**2) - ra;
      db = root_round((q[0]-b[0])**2 + (q[1]-b[1])**2 + (q[2]-b[2])**2) - rb;
      ds = root_round((q[1]-ay)**2 + (q[2]-az)**2) - rs;
      if (q[0] < a[0]) begin
         val = da; res.region = REGION_ONE;
      end else if (q[0] >= b[0]) begin
         val = db; res.region = REGION_TWO;
      end else if (2 * q[0] <= s[0]) begin
         rad = (q[1]-a[1])**2 + (q[2]-a[2])**2;
         if (rad > rs * rs && q[0] <= a[0] + ra) begin
            val = da; res.region = REGION_ONE;
         end else if (da <= 0) begin
            val = -root_round(da*da + ds*ds); res.region = REGION_NECK;
         end else begin
            val = ds; res.region = REGION_SHAFT;
         end
      end else begin
         rad = (q[1]-b[1])**2 + (q[2]-b[2])**2;
         if (rad > rs * rs && q[0] >= b[0] - rb) begin
            val = db; res.region = REGION_TWO;
         end else if (db < 0) begin
            val = -root_round(db*db + ds*ds); res.region = REGION_NECK;
         end else begin
            val = ds; res.region = REGION_SHAFT;
         end
      end
      if (val > 131071) val = 131071;
      if (val < -131072) val = -131072;
      res.level = val[LEVEL_W-1:0];
      return res;
   endfunction

   // driver: offer queued points, idling at random unless quiet
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (point_q.size() != 0 && (quiet || $urandom_range(99) >= 32)) begin
            req_tvalid <= 1'b1;
            req_tdata <= point_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
         hold_done <= 1'b0;
      end else if (hold_go && !hold_done) begin
         if (hold_cnt < 400) hold_cnt <= hold_cnt + 1;
         else hold_done <= 1'b1;
      end
   end

   // receiver ready
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_go && !hold_done) rsp_tready <= 1'b0;
      else rsp_tready <= quiet || $urandom_range(99) >= 32;
   end

   // predict at input accept, check at output accept
   always @(posedge clock) begin
      level_result_type want;
      if (!reset && req_tvalid && req_tready) level_q.push_back(barbell_level(req_tdata));
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (level_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h", rsp_tdata);
         end else begin
            want = level_q.pop_front();
            if (rsp_tdata[17:0] !== want.level || rsp_tdata[19:18] !== want.region
                || rsp_tdata[23:20] !== 4'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected level %0d region %0d, got level %0d region %0d",
                           want.level, want.region, $signed(rsp_tdata[17:0]),
                           rsp_tdata[19:18]);
            end
         end
      end
   end

   // watchdog on cycles without any accept
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 3000) begin
         $display("** barbell_level_set_eval: FAILED **");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ROW_0:      rot_row[0] = val;
         CSR_ROW_1:      rot_row[1] = val;
         CSR_ROW_2:      rot_row[2] = val;
         CSR_CENTRE_ONE: ctr_one = val;
         CSR_CENTRE_TWO: ctr_two = val;
         CSR_RADII:      radius_set = val;
         CSR_SHAFT_AXIS: axis_pos = val[AXIS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_config(input logic [CFG_W-1:0] r0, r1, r2, c1, c2, rr, ax);
      write_csr(CSR_ROW_0, r0);
      write_csr(CSR_ROW_1, r1);
      write_csr(CSR_ROW_2, r2);
      write_csr(CSR_CENTRE_ONE, c1);
      write_csr(CSR_CENTRE_TWO, c2);
      write_csr(CSR_RADII, rr);
      write_csr(CSR_SHAFT_AXIS, ax);
   endtask

   task automatic push_point(input int x, y, z);
      point_q.push_back({z[15:0], y[15:0], x[15:0]});
   endtask

   // mostly points around the barbell, the rest anywhere
   task automatic push_random(input int n);
      int cx, cy, cz, span;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 70) begin
            cx = (lane_sgn(ctr_one, 0) + lane_sgn(ctr_two, 0)) / 2;
            cy = lane_sgn(ctr_one, 1);
            cz = lane_sgn(ctr_one, 2);
            span = $urandom_range(1, 4) * 2048;
            push_point(cx + $urandom_range(0, 2*span) - span,
                       cy + $urandom_range(0, span) - span/2,
                       cz + $urandom_range(0, span) - span/2);
         end else begin
            push_point($urandom, $urandom, $urandom);
         end
      end
   endtask

   // let every queued point drain, then let the pipeline settle
   task automatic drain;
      do @(negedge clock);
      while (point_q.size() != 0 || req_tvalid || level_q.size() != 0);
      repeat (80) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      rot_row[0] = RST_ROW_0;
      rot_row[1] = RST_ROW_1;
      rot_row[2] = RST_ROW_2;
      ctr_one = RST_CENTRE_ONE;
      ctr_two = RST_CENTRE_TWO;
      radius_set = RST_RADII;
      axis_pos = RST_SHAFT_AXIS;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed points on reset configuration: extremes and region borders
      push_point(0, 0, 0);
      push_point(32767, 32767, 32767);
      push_point(-32768, -32768, -32768);
      push_point(32767, -32768, 0);
      push_point(4914, 8192, 8192);
      push_point(4915, 8192, 8192);
      push_point(11468, 8192, 8192);
      push_point(11469, 8192, 8192);
      push_point(8192, 8192, 8192);
      push_point(8193, 8192, 8192);
      push_point(6000, 9192, 8192);
      push_point(6553, 9192, 8192);
      push_point(6554, 9192, 8192);
      push_point(7000, 8600, 8192);
      push_point(9831, 8192, 7192);
      push_point(9830, 8192, 7192);
      push_point(10000, 8684, 8192);
      push_point(6000, 8684, 8192);
      push_point(8192, 9000, 9000);
      push_point(6200, 8192, 8192);
      drain();

      // defaults written explicitly, unused index, then random with a hold-off
      load_config(RST_ROW_0, RST_ROW_1, RST_ROW_2, RST_CENTRE_ONE, RST_CENTRE_TWO,
                  RST_RADII, RST_SHAFT_AXIS);
      write_csr(3'd7, '1);
      push_random(120);
      @(negedge clock);
      hold_go = 1'b1;
      push_random(130);
      drain();

      // quarter turn about z, no idling
      quiet = 1'b1;
      load_config({16'd0, 16'hC000, 16'd0}, {16'd0, 16'd0, 16'd16384},
                  {16'd16384, 16'd0, 16'd0}, {16'd4000, 16'd8000, 16'd2000},
                  {16'd9000, 16'd8000, 16'd14000}, {16'd3000, 16'd1200, 16'd2000},
                  {16'd0, 16'd14000, 16'd8000});
      push_random(200);
      drain();
      quiet = 1'b0;

      // extreme coefficients and radii, saturating values
      load_config('1, {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF},
                  {16'h8000, 16'h8000, 16'h8000}, {16'h7FFF, 16'h7FFF, 16'h7FFF},
                  '1, 48'h0000_7FFF_8000);
      push_random(150);
      drain();

      // zero everything
      load_config('0, '0, '0, '0, '0, '0, '0);
      push_random(30);
      drain();

      // swapped centres
      load_config(RST_ROW_0, RST_ROW_1, RST_ROW_2, RST_CENTRE_TWO, RST_CENTRE_ONE,
                  RST_RADII, RST_SHAFT_AXIS);
      push_random(120);
      drain();

      // fully random configuration
      load_config(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                  CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                  CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                  CFG_W'({$urandom, $urandom}));
      push_random(200);
      drain();

      if (mismatches == 0) $display("** barbell_level_set_eval: PASSED **");
      else $display("** barbell_level_set_eval: FAILED **");
      $finish;
   end

endmodule

// ----- barbell_level_set_eval.f -----
src/ble_pkg.sv
src/ble_sqrt.sv
src/ble_queue.sv
src/ble_front.sv
src/ble_back.sv
src/barbell_level_set_eval.sv
tb/sv/tb.sv
